### rtl/dss_pkg.sv
// Shared types, codes and constants of the drum step sequencer.
package dss_pkg;

    // Pattern and timing constants
    localparam int STEPS_DEF     = 16;
    localparam int TRACKS        = 8;
    localparam int TICK_MS       = 1;
    localparam int BPM_LOW       = 40;
    localparam int BPM_HIGH      = 240;
    localparam int MS_PER_MINUTE = 60000;

    // Step length = ((60000/bpm)/4)/TICK_MS = 15000 / (bpm*TICK_MS)
    localparam int DIVIDEND      = MS_PER_MINUTE / 4;
    localparam int DIVIDEND_W    = $clog2(DIVIDEND + 1);
    localparam int DIVISOR_W     = $clog2(BPM_HIGH * TICK_MS + 1);
    localparam int LEN_W         = 12;

    localparam logic [7:0] TRACK_MASK = 8'((1 << TRACKS) - 1);
    localparam logic [7:0] NO_VALUE   = 8'hFF;

    // Input opcodes
    localparam logic [3:0] OP_TICK     = 4'd0;
    localparam logic [3:0] OP_PLAY     = 4'd1;
    localparam logic [3:0] OP_STOP     = 4'd2;
    localparam logic [3:0] OP_SET_BIT  = 4'd3;
    localparam logic [3:0] OP_GET_BIT  = 4'd4;
    localparam logic [3:0] OP_SET_MASK = 4'd5;
    localparam logic [3:0] OP_GET_MASK = 4'd6;
    localparam logic [3:0] OP_CLEAR    = 4'd7;
    localparam logic [3:0] OP_STATUS   = 4'd8;

    // Result kinds
    localparam logic [1:0] KIND_NOTE_OFF = 2'd0;
    localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
    localparam logic [1:0] KIND_READ     = 2'd2;
    localparam logic [1:0] KIND_STATUS   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_TEMPO      = 2'd0;
    localparam logic [1:0] CFG_PROGRAM    = 2'd1;
    localparam logic [1:0] CFG_VELOCITIES = 2'd2;

    typedef struct packed {
        logic [3:0] opcode;
        logic       loop_flag;
        logic [3:0] step_index;
        logic [2:0] track_index;
        logic       bit_on;
        logic [7:0] step_mask;
    } t_in_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] track_id;
        logic [7:0] velocity;
        logic [7:0] program_out;
        logic [7:0] read_value;
        logic       playing_out;
        logic       last;
    } t_out_item;

    typedef enum logic [3:0] {
        CMD_TICK,
        CMD_PLAY,
        CMD_STOP,
        CMD_SET_BIT,
        CMD_GET_BIT,
        CMD_SET_MASK,
        CMD_GET_MASK,
        CMD_CLEAR,
        CMD_STATUS
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op    op;
        logic       loop_flag;
        logic [3:0] step_index;
        logic [2:0] track_index;
        logic       bit_on;
        logic [7:0] step_mask;
        logic       st_ok;
        logic       tr_ok;
    } t_cmd;

    typedef struct packed {
        logic        we;
        logic [1:0]  idx;
        logic [63:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic                 start;
        logic [DIVISOR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] quotient;
    } t_div_rsp;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_RD_PREV,
        BK_RD_CUR,
        BK_WR_BIT,
        BK_REPLY,
        BK_EMIT
    } t_back_state;

endpackage

### rtl/drum_step_sequencer.sv
// Top level of the drum step sequencer: front end, divider and back end.
//
//  channel  | ports                                 | accepted when
//  ---------+---------------------------------------+---------------------------
//  input    | push, full, i_in_item                 | push && !full
//  result   | empty, pop, o_out_item                | pop && !empty
//  config   | i_cfg_we, i_cfg_idx, i_cfg_data       | i_cfg_we
//
// The front end takes one item a cycle, while not full, into a two-entry
// command queue. The back end runs one command at a time: set_bit reads and
// then writes its step, a read or status reply waits for a free result
// register, play waits for the serial step-length divider, and a due tick
// reads two steps and emits up to 16 note events, one a cycle unless stalled.
// Reset is synchronous; pattern valid bits clear at once, no clearing pass.
// A held result stalls the back end only; the front keeps filling its queue.
module drum_step_sequencer import dss_pkg::*; #(
    parameter int STEPS = STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_in_item    i_in_item,
    output logic        empty,
    input  logic        pop,
    output t_out_item   o_out_item,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);

    t_cmd     cmd;
    logic     cmd_valid;
    logic     cmd_pop;
    t_cfg_wr  cfg;
    t_div_req div_req;
    t_div_rsp div_rsp;
    logic     out_valid;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;
    assign empty    = !out_valid;

    dss_front #(
        .STEPS(STEPS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .o_cmd      (cmd),
        .o_cmd_valid(cmd_valid),
        .i_cmd_pop  (cmd_pop)
    );

    dss_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    dss_back #(
        .STEPS(STEPS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_cmd_valid(cmd_valid),
        .o_cmd_pop  (cmd_pop),
        .i_cfg      (cfg),
        .o_div_req  (div_req),
        .i_div_rsp  (div_rsp),
        .o_out_item (o_out_item),
        .o_out_valid(out_valid),
        .i_pop      (pop)
    );

endmodule

### rtl/dss_front.sv
// Front end: accepts items, classifies opcodes and queues commands for the back end.
module dss_front import dss_pkg::*; #(
    parameter int STEPS = STEPS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    output logic     full,
    input  t_in_item i_in_item,
    output t_cmd     o_cmd,
    output logic     o_cmd_valid,
    input  logic     i_cmd_pop
);

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    t_cmd       dec_cmd;
    logic       dec_known;
    logic       accept;
    logic       enq;
    logic       deq;

    // Opcode classification and range checks
    always_comb begin
        dec_cmd.op          = CMD_TICK;
        dec_cmd.loop_flag   = i_in_item.loop_flag;
        dec_cmd.step_index  = i_in_item.step_index;
        dec_cmd.track_index = i_in_item.track_index;
        dec_cmd.bit_on      = i_in_item.bit_on;
        dec_cmd.step_mask   = i_in_item.step_mask;
        dec_cmd.st_ok       = int'(i_in_item.step_index) < STEPS;
        dec_cmd.tr_ok       = int'(i_in_item.track_index) < TRACKS;
        dec_known           = 1'b1;
        case (i_in_item.opcode)
            OP_TICK:     dec_cmd.op = CMD_TICK;
            OP_PLAY:     dec_cmd.op = CMD_PLAY;
            OP_STOP:     dec_cmd.op = CMD_STOP;
            OP_SET_BIT:  dec_cmd.op = CMD_SET_BIT;
            OP_GET_BIT:  dec_cmd.op = CMD_GET_BIT;
            OP_SET_MASK: dec_cmd.op = CMD_SET_MASK;
            OP_GET_MASK: dec_cmd.op = CMD_GET_MASK;
            OP_CLEAR:    dec_cmd.op = CMD_CLEAR;
            OP_STATUS:   dec_cmd.op = CMD_STATUS;
            default:     dec_known  = 1'b0;
        endcase
    end

    // Unknown opcodes are taken and dropped
    assign full        = (r_count == 2'd2);
    assign accept      = push && !full;
    assign enq         = accept && dec_known;
    assign o_cmd_valid = (r_count != 2'd0);
    assign deq         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_slot[r_rd_ptr];

    // Two-entry command queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (enq) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (deq) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (enq && !deq) begin
                r_count <= r_count + 2'd1;
            end else if (deq && !enq) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_slot[r_wr_ptr] <= dec_cmd;
        end
    end

endmodule

### rtl/dss_divider.sv
// Restoring divider: step length from the clamped tempo, one quotient bit a cycle.
module dss_divider import dss_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_div;

    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    // Shift in the next dividend bit and try a subtract
    assign trial = {r_rem, r_quo[DIVIDEND_W-1]};
    assign fits  = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= DIVIDEND_W'(DIVIDEND);
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= fits ? DIVISOR_W'(trial - {1'b0, r_div}) : trial[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], fits};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo[LEN_W-1:0];

endmodule

### rtl/dss_back.sv
// Back end: pattern memory, playback state, command execution and result register.
module dss_back import dss_pkg::*; #(
    parameter int STEPS = STEPS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  logic      i_cmd_valid,
    output logic      o_cmd_pop,
    input  t_cfg_wr   i_cfg,
    output t_div_req  o_div_req,
    input  t_div_rsp  i_div_rsp,
    output t_out_item o_out_item,
    output logic      o_out_valid,
    input  logic      i_pop
);

    localparam int SW = $clog2(STEPS);

    // Configuration registers
    logic [7:0]  r_tempo;
    logic [7:0]  r_program;
    logic [63:0] r_velocities;

    // Playback state
    t_back_state r_state, n_state;
    t_cmd        r_cmd, n_cmd;
    logic        r_playing, n_playing;
    logic        r_loop, n_loop;
    logic [SW-1:0] r_cur_step, n_cur_step;
    logic [SW-1:0] r_prev_step, n_prev_step;
    logic        r_prev_valid, n_prev_valid;
    logic [LEN_W-1:0] r_step_len, n_step_len;
    logic [LEN_W-1:0] r_wait, n_wait;
    logic [7:0]  r_off, n_off;
    logic [7:0]  r_on, n_on;

    // Pattern memory with per-step valid bits
    logic [7:0]  r_mem [STEPS];
    logic        r_vld [STEPS];
    logic [7:0]  r_rd_data;
    logic        r_rd_vld;

    // Result register
    t_out_item   r_out, n_out;
    logic        r_out_valid;

    logic          out_free;
    logic          out_load;
    logic [SW-1:0] rd_addr;
    logic [SW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_we;
    logic          vld_clr;
    logic          div_start;
    logic [SW-1:0] head_st;
    logic [SW-1:0] cmd_st;
    logic [7:0]    rd_mask;
    logic [7:0]    bit_sel;

    logic [7:0]    emit_src;
    logic          emit_is_off;
    logic [2:0]    emit_idx;
    logic [7:0]    emit_clr;
    logic [7:0]    emit_rest;
    logic          emit_last;

    logic [7:0]           bpm_clamped;
    logic [DIVISOR_W-1:0] divisor;

    function automatic logic [2:0] lowest_bit(input logic [7:0] m);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (m[i]) begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

    assign head_st  = SW'(i_cmd.step_index);
    assign cmd_st   = SW'(r_cmd.step_index);
    assign rd_mask  = r_rd_vld ? r_rd_data : 8'd0;
    assign out_free = !r_out_valid || i_pop;
    assign bit_sel  = 8'd1 << r_cmd.track_index;

    // Tempo clamp and divisor for the step length
    always_comb begin
        bpm_clamped = r_tempo;
        if (int'(r_tempo) < BPM_LOW) begin
            bpm_clamped = 8'(BPM_LOW);
        end else if (int'(r_tempo) > BPM_HIGH) begin
            bpm_clamped = 8'(BPM_HIGH);
        end
    end
    assign divisor           = DIVISOR_W'(bpm_clamped) * DIVISOR_W'(TICK_MS);
    assign o_div_req.start   = div_start;
    assign o_div_req.divisor = divisor;

    // Note event selection: note-offs first, lowest track first
    assign emit_is_off = (r_off != 8'd0);
    assign emit_src    = emit_is_off ? r_off : r_on;
    assign emit_idx    = lowest_bit(emit_src);
    assign emit_clr    = emit_src & ~(8'd1 << emit_idx);
    assign emit_rest   = emit_is_off ? (emit_clr | r_on) : emit_clr;
    assign emit_last   = (emit_rest == 8'd0);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tempo      <= 8'd120;
            r_program    <= 8'd0;
            r_velocities <= 64'd0;
        end else if (i_cfg.we) begin
            case (i_cfg.idx)
                CFG_TEMPO:      r_tempo      <= i_cfg.data[7:0];
                CFG_PROGRAM:    r_program    <= i_cfg.data[7:0];
                CFG_VELOCITIES: r_velocities <= i_cfg.data;
                default:        ;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        CMD_TICK: begin
                            if (r_playing && (r_wait == '0)) begin
                                n_state = BK_RD_PREV;
                            end
                        end
                        CMD_PLAY:    n_state = BK_DIV;
                        CMD_SET_BIT: begin
                            if (i_cmd.st_ok && i_cmd.tr_ok) begin
                                n_state = BK_WR_BIT;
                            end
                        end
                        CMD_GET_BIT, CMD_GET_MASK, CMD_STATUS: n_state = BK_REPLY;
                        default:     n_state = BK_IDLE;
                    endcase
                end
            end
            BK_DIV: begin
                if (i_div_rsp.done) begin
                    n_state = BK_IDLE;
                end
            end
            BK_RD_PREV: n_state = BK_RD_CUR;
            BK_RD_CUR: begin
                if ((r_off | (rd_mask & TRACK_MASK)) != 8'd0) begin
                    n_state = BK_EMIT;
                end else begin
                    n_state = BK_IDLE;
                end
            end
            BK_WR_BIT: n_state = BK_IDLE;
            BK_REPLY: begin
                if (out_free) begin
                    n_state = BK_IDLE;
                end
            end
            BK_EMIT: begin
                if (out_free && emit_last) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // Datapath controls and next values
    always_comb begin
        o_cmd_pop    = 1'b0;
        rd_addr      = cmd_st;
        mem_waddr    = cmd_st;
        mem_wdata    = r_cmd.step_mask;
        mem_we       = 1'b0;
        vld_clr      = 1'b0;
        div_start    = 1'b0;
        out_load     = 1'b0;
        n_out        = r_out;
        n_cmd        = r_cmd;
        n_playing    = r_playing;
        n_loop       = r_loop;
        n_cur_step   = r_cur_step;
        n_prev_step  = r_prev_step;
        n_prev_valid = r_prev_valid;
        n_step_len   = r_step_len;
        n_wait       = r_wait;
        n_off        = r_off;
        n_on         = r_on;
        case (r_state)
            BK_IDLE: begin
                rd_addr   = (i_cmd.op == CMD_TICK) ? r_prev_step : head_st;
                mem_waddr = head_st;
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    case (i_cmd.op)
                        CMD_TICK: begin
                            if (r_playing && (r_wait != '0)) begin
                                n_wait = r_wait - LEN_W'(1);
                            end
                        end
                        CMD_PLAY: begin
                            div_start    = 1'b1;
                            n_cur_step   = '0;
                            n_prev_valid = 1'b0;
                            n_loop       = i_cmd.loop_flag;
                            n_wait       = '0;
                            n_playing    = 1'b1;
                        end
                        CMD_STOP: n_playing = 1'b0;
                        CMD_SET_MASK: begin
                            if (i_cmd.st_ok) begin
                                mem_we    = 1'b1;
                                mem_wdata = i_cmd.step_mask;
                            end
                        end
                        CMD_CLEAR: vld_clr = 1'b1;
                        default:   ;
                    endcase
                end
            end
            BK_DIV: begin
                if (i_div_rsp.done) begin
                    n_step_len = i_div_rsp.quotient;
                end
            end
            BK_RD_PREV: begin
                rd_addr = r_cur_step;
                n_off   = r_prev_valid ? (rd_mask & TRACK_MASK) : 8'd0;
            end
            BK_RD_CUR: begin
                n_on         = rd_mask & TRACK_MASK;
                n_prev_step  = r_cur_step;
                n_prev_valid = 1'b1;
                n_wait       = (r_step_len != '0) ? (r_step_len - LEN_W'(1)) : '0;
                if (r_cur_step == SW'(STEPS - 1)) begin
                    n_cur_step = '0;
                    if (!r_loop) begin
                        n_playing = 1'b0;
                    end
                end else begin
                    n_cur_step = r_cur_step + SW'(1);
                end
            end
            BK_WR_BIT: begin
                mem_we    = 1'b1;
                mem_wdata = r_cmd.bit_on ? (rd_mask | bit_sel) : (rd_mask & ~bit_sel);
            end
            BK_REPLY: begin
                if (out_free) begin
                    out_load          = 1'b1;
                    n_out.kind        = KIND_READ;
                    n_out.track_id    = 3'd0;
                    n_out.velocity    = 8'd0;
                    n_out.program_out = 8'd0;
                    n_out.playing_out = 1'b0;
                    n_out.last        = 1'b1;
                    case (r_cmd.op)
                        CMD_GET_BIT: begin
                            n_out.read_value = (r_cmd.st_ok && r_cmd.tr_ok) ?
                                {7'd0, rd_mask[r_cmd.track_index]} : NO_VALUE;
                        end
                        CMD_GET_MASK: begin
                            n_out.read_value = r_cmd.st_ok ? rd_mask : NO_VALUE;
                        end
                        default: begin
                            n_out.kind        = KIND_STATUS;
                            n_out.read_value  = r_playing ? 8'(r_cur_step) : NO_VALUE;
                            n_out.playing_out = r_playing;
                        end
                    endcase
                end
            end
            BK_EMIT: begin
                if (out_free) begin
                    out_load          = 1'b1;
                    n_out.kind        = emit_is_off ? KIND_NOTE_OFF : KIND_NOTE_ON;
                    n_out.track_id    = emit_idx;
                    n_out.velocity    = emit_is_off ? 8'd0 :
                                        r_velocities[{emit_idx, 3'b000} +: 8];
                    n_out.program_out = r_program;
                    n_out.read_value  = 8'd0;
                    n_out.playing_out = 1'b0;
                    n_out.last        = emit_last;
                    if (emit_is_off) begin
                        n_off = emit_clr;
                    end else begin
                        n_on = emit_clr;
                    end
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BK_IDLE;
            r_playing    <= 1'b0;
            r_loop       <= 1'b0;
            r_cur_step   <= '0;
            r_prev_step  <= '0;
            r_prev_valid <= 1'b0;
            r_step_len   <= '0;
            r_wait       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_playing    <= n_playing;
            r_loop       <= n_loop;
            r_cur_step   <= n_cur_step;
            r_prev_step  <= n_prev_step;
            r_prev_valid <= n_prev_valid;
            r_step_len   <= n_step_len;
            r_wait       <= n_wait;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_off <= n_off;
        r_on  <= n_on;
        if (out_load) begin
            r_out <= n_out;
        end
    end

    // Pattern memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Valid bits: an unwritten or cleared step reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STEPS; i++) begin
                r_vld[i] <= 1'b0;
            end
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[rd_addr];
            if (vld_clr) begin
                for (int i = 0; i < STEPS; i++) begin
                    r_vld[i] <= 1'b0;
                end
            end else if (mem_we) begin
                r_vld[mem_waddr] <= 1'b1;
            end
        end
    end

    assign o_out_item  = r_out;
    assign o_out_valid = r_out_valid;

    // Checks
    a_emit_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_EMIT) |-> ((r_off | r_on) != 8'd0))
        else $error("emit state with no pending note");

    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_step <= SW'(STEPS - 1))
        else $error("current step out of range");

    a_due_sets_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_RD_CUR) |=> r_prev_valid)
        else $error("due step did not record previous step");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || i_pop))
        else $error("result register overwritten before pop");

    a_div_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_div_rsp.done |-> (r_state == BK_DIV))
        else $error("divider finished outside play setup");

endmodule

### dv/drum_step_sequencer_test.sv
// Self-checking testbench of the drum step sequencer: directed and random command items.
module drum_step_sequencer_test;
    import dss_pkg::*;

    localparam int         NUM_STEPS   = STEPS_DEF;
    localparam logic [1:0] CFG_SPARE   = 2'd3;     // index past the register list
    localparam int         QUIET_WAIT  = 64;       // cycles for commands that give no result
    localparam int         ERR_PRINTS  = 50;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        push     = 1'b0;
    logic        pop      = 1'b0;
    logic        full;
    logic        empty;
    t_in_item    in_item  = '0;
    t_out_item   out_item;
    logic        cfg_we   = 1'b0;
    logic [1:0]  cfg_idx  = '0;
    logic [63:0] cfg_data = '0;

    // Sequencer state as predicted
    logic [7:0]  pat_masks [NUM_STEPS];
    bit          run_on;
    bit          loop_on;
    logic [3:0]  step_now;
    logic [3:0]  step_prev;
    bit          prev_known;
    int unsigned ticks_per_step;
    int unsigned ticks_left;
    logic [7:0]  tempo_reg;
    logic [7:0]  program_reg;
    logic [63:0] velocity_reg;

    // Note events and replies still owed by the block, oldest first
    t_out_item   pending_events [$];

    int fault_count = 0;
    int due_count   = 0;
    int live_items  = 0;
    int drain_wait  = 0;
    bit feed_idle   = 1'b1;
    bit drain_idle  = 1'b1;

    drum_step_sequencer dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (fault_count < ERR_PRINTS) begin
            $display("ERROR at %0t: %s: got %0h, want %0h", $time, what, got, want);
        end
        fault_count++;
    endtask

    task automatic add_event(logic [1:0] kind, logic [2:0] trk, logic [7:0] vel,
                             logic [7:0] prog, logic [7:0] value, logic playing);
        t_out_item ev;
        ev.kind        = kind;
        ev.track_id    = trk;
        ev.velocity    = vel;
        ev.program_out = prog;
        ev.read_value  = value;
        ev.playing_out = playing;
        ev.last        = 1'b0;
        pending_events.push_back(ev);
    endtask

    // A due tick: note-offs of the previous step, note-ons of this one, then advance
    task automatic play_due_step();
        logic [7:0] mask;
        int         next;
        if (prev_known) begin
            mask = pat_masks[step_prev];
            for (int t = 0; t < TRACKS; t++) begin
                if (mask[t]) begin
                    add_event(KIND_NOTE_OFF, 3'(t), 8'd0, program_reg, 8'd0, 1'b0);
                end
            end
        end
        mask = pat_masks[step_now];
        for (int t = 0; t < TRACKS; t++) begin
            if (mask[t]) begin
                add_event(KIND_NOTE_ON, 3'(t), velocity_reg[8*t +: 8], program_reg, 8'd0, 1'b0);
            end
        end
        step_prev  = step_now;
        prev_known = 1'b1;
        ticks_left = (ticks_per_step > 0) ? ticks_per_step - 1 : 0;
        next = int'(step_now) + 1;
        if (next >= NUM_STEPS) begin
            next = 0;
            if (!loop_on) begin
                run_on = 1'b0;
            end
        end
        step_now = 4'(next);
        due_count++;
    endtask

    // Predicts the results of one accepted item; acted is low when the item is ignored
    task automatic apply_command(t_in_item it, output bit acted);
        int unsigned bpm;
        int          base_count;
        bit          st_ok;
        t_out_item   tail;
        base_count = pending_events.size();
        st_ok      = int'(it.step_index) < NUM_STEPS;
        acted      = 1'b1;
        case (it.opcode)
            OP_TICK: begin
                acted = run_on;
                if (run_on) begin
                    if (ticks_left > 0) begin
                        ticks_left--;
                    end else begin
                        play_due_step();
                    end
                end
            end
            OP_PLAY: begin
                bpm = 32'(tempo_reg);
                if (bpm < BPM_LOW) begin
                    bpm = BPM_LOW;
                end
                if (bpm > BPM_HIGH) begin
                    bpm = BPM_HIGH;
                end
                ticks_per_step = ((MS_PER_MINUTE / bpm) / 4) / TICK_MS;
                step_now   = '0;
                prev_known = 1'b0;
                loop_on    = it.loop_flag;
                ticks_left = 0;
                run_on     = 1'b1;
            end
            OP_STOP: begin
                run_on = 1'b0;
            end
            OP_SET_BIT: begin
                if (st_ok) begin
                    pat_masks[it.step_index][it.track_index] = it.bit_on;
                end
            end
            OP_GET_BIT: begin
                add_event(KIND_READ, 3'd0, 8'd0, 8'd0,
                          st_ok ? {7'd0, pat_masks[it.step_index][it.track_index]} : NO_VALUE,
                          1'b0);
            end
            OP_SET_MASK: begin
                if (st_ok) begin
                    pat_masks[it.step_index] = it.step_mask;
                end
            end
            OP_GET_MASK: begin
                add_event(KIND_READ, 3'd0, 8'd0, 8'd0,
                          st_ok ? pat_masks[it.step_index] : NO_VALUE, 1'b0);
            end
            OP_CLEAR: begin
                foreach (pat_masks[s]) begin
                    pat_masks[s] = '0;
                end
            end
            OP_STATUS: begin
                add_event(KIND_STATUS, 3'd0, 8'd0, 8'd0,
                          run_on ? {4'd0, step_now} : NO_VALUE, run_on);
            end
            default: begin
                acted = 1'b0;
            end
        endcase
        // Mark the final result of this item
        if (pending_events.size() > base_count) begin
            tail = pending_events.pop_back();
            tail.last = 1'b1;
            pending_events.push_back(tail);
        end
    endtask

    function automatic t_in_item make_item(logic [3:0] op);
        t_in_item it;
        it = 21'($urandom);
        it.opcode = op;
        return it;
    endfunction

    // Hands one item over; push stays high, unless a random gap follows, so the next item can follow at once
    task automatic send_item(t_in_item it);
        bit acted;
        int gap;
        push    <= 1'b1;
        in_item <= it;
        do begin
            @(posedge clk);
        end while (full !== 1'b0);
        apply_command(it, acted);
        if (acted) begin
            live_items++;
        end
        if (feed_idle && $urandom_range(0, 3) == 0) begin
            gap = pick_gap();
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic issue(logic [3:0] op, logic [3:0] st = 4'd0, logic [2:0] tr = 3'd0,
                         logic on = 1'b0, logic [7:0] mk = 8'd0, logic lp = 1'b0);
        t_in_item it;
        it = make_item(op);
        it.step_index  = st;
        it.track_index = tr;
        it.bit_on      = on;
        it.step_mask   = mk;
        it.loop_flag   = lp;
        send_item(it);
    endtask

    // Ticks until the wanted number of steps has played or playback has ended
    task automatic run_dues(int want);
        int goal;
        goal = due_count + want;
        while (run_on && due_count < goal) begin
            send_item(make_item(OP_TICK));
        end
    endtask

    // Idle: every result in, then room for commands that give none
    task automatic wait_idle();
        push <= 1'b0;
        while (pending_events.size() != 0) begin
            @(posedge clk);
        end
        repeat (QUIET_WAIT) @(posedge clk);
    endtask

    task automatic put_reg(logic [1:0] idx, logic [63:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            CFG_TEMPO:      tempo_reg    = value[7:0];
            CFG_PROGRAM:    program_reg  = value[7:0];
            CFG_VELOCITIES: velocity_reg = value;
            default: ;
        endcase
    endtask

    task automatic load_regs(logic [7:0] tempo, logic [7:0] prog, logic [63:0] vel,
                             bit touch_spare);
        put_reg(CFG_TEMPO, {$urandom, 24'($urandom), tempo});
        put_reg(CFG_PROGRAM, {$urandom, 24'($urandom), prog});
        put_reg(CFG_VELOCITIES, vel);
        if (touch_spare) begin
            put_reg(CFG_SPARE, {$urandom, $urandom});
        end
        cfg_we <= 1'b0;
    endtask

    // Reads, ignored ticks, a stop and unknown codes right after reset
    task automatic test_power_up();
        issue(OP_STATUS);
        issue(OP_GET_MASK, 4'd15);
        issue(OP_GET_BIT, 4'd0, 3'd7);
        issue(OP_TICK);
        issue(OP_STOP);
        issue(4'd15);
        issue(4'd9);
    endtask

    task automatic test_pattern_edits();
        issue(OP_SET_MASK, 4'd0, 3'd0, 1'b0, 8'hFF);
        issue(OP_SET_BIT, 4'd15, 3'd7, 1'b1);
        issue(OP_SET_BIT, 4'd0, 3'd0, 1'b0);
        issue(OP_GET_MASK, 4'd0);
        issue(OP_GET_BIT, 4'd15, 3'd7);
        issue(OP_GET_BIT, 4'd0, 3'd0);
        issue(OP_CLEAR);
        issue(OP_GET_MASK, 4'd15);
    endtask

    // One pass without loop at the top tempo; empty steps give no result
    task automatic test_single_pass();
        wait_idle();
        load_regs(8'd255, 8'hFF, '1, 1'b1);
        issue(OP_SET_MASK, 4'd0, 3'd0, 1'b0, 8'h01);
        issue(OP_SET_MASK, 4'd1, 3'd0, 1'b0, 8'h80);
        issue(OP_SET_MASK, 4'd15, 3'd0, 1'b0, 8'hFF);
        issue(OP_PLAY, 4'd0, 3'd0, 1'b0, 8'd0, 1'b0);
        run_dues(NUM_STEPS + 1);
        issue(OP_STATUS);
        issue(OP_TICK);
    endtask

    // Wrap in loop mode, restart while playing, stop without note-offs
    task automatic test_loop_restart();
        wait_idle();
        load_regs(8'd241, 8'd0, {$urandom, $urandom}, 1'b0);
        for (int s = 0; s < NUM_STEPS; s += 3) begin
            issue(OP_SET_MASK, 4'(s), 3'd0, 1'b0, 8'($urandom));
        end
        issue(OP_PLAY, 4'd0, 3'd0, 1'b0, 8'd0, 1'b1);
        run_dues(NUM_STEPS + 2);
        issue(OP_STATUS);
        issue(OP_PLAY, 4'd0, 3'd0, 1'b0, 8'd0, 1'b0);
        run_dues(2);
        issue(OP_STOP);
        issue(OP_STATUS);
        issue(OP_TICK);
    endtask

    // Tempos below the floor clamp to the slowest step length
    task automatic test_slow_tempo();
        wait_idle();
        load_regs(8'd0, 8'd1, {$urandom, $urandom}, 1'b0);
        issue(OP_PLAY, 4'd0, 3'd0, 1'b0, 8'd0, 1'b1);
        run_dues(2);
        issue(OP_STATUS);
        wait_idle();
        load_regs(8'd39, 8'd128, {$urandom, $urandom}, 1'b0);
        issue(OP_PLAY, 4'd0, 3'd0, 1'b0, 8'd0, 1'b0);
        run_dues(2);
        issue(OP_STOP);
    endtask

    // Phases of play plus ticks with random edits, reads and noise between them
    task automatic test_random();
        int         phase;
        int         pick;
        int         burst;
        int         live_goal;
        logic [7:0] tempo;
        live_goal = live_items + 150;
        for (phase = 0; phase < 60 && live_items < live_goal; phase++) begin
            wait_idle();
            feed_idle  = (phase % 4) != 2;
            drain_idle = (phase % 4) != 3;
            case ($urandom_range(0, 7))
                0:       tempo = 8'd0;
                1:       tempo = 8'd39;
                2:       tempo = 8'd40;
                3:       tempo = 8'd240;
                4:       tempo = 8'd241;
                5:       tempo = 8'd255;
                default: tempo = 8'($urandom_range(41, 239));
            endcase
            load_regs(tempo, 8'($urandom), {$urandom, $urandom}, $urandom_range(0, 3) == 0);
            send_item(make_item(OP_PLAY));
            repeat ($urandom_range(10, 24)) begin
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    if (!run_on && $urandom_range(0, 1) == 1) begin
                        send_item(make_item(OP_PLAY));
                    end
                    burst = run_on ? $urandom_range(1, 6) : $urandom_range(1, 3);
                    repeat (burst) send_item(make_item(OP_TICK));
                end else if (pick < 55) begin
                    send_item(make_item(OP_SET_MASK));
                end else if (pick < 63) begin
                    send_item(make_item(OP_SET_BIT));
                end else if (pick < 70) begin
                    send_item(make_item(OP_GET_MASK));
                end else if (pick < 76) begin
                    send_item(make_item(OP_GET_BIT));
                end else if (pick < 82) begin
                    send_item(make_item(OP_STATUS));
                end else if (pick < 86) begin
                    send_item(make_item(OP_PLAY));
                end else if (pick < 89) begin
                    send_item(make_item(OP_STOP));
                end else if (pick < 91) begin
                    send_item(make_item(OP_CLEAR));
                end else if (pick < 95) begin
                    send_item(make_item(4'($urandom_range(9, 15))));
                end else begin
                    send_item(make_item(4'($urandom)));
                end
            end
        end
        feed_idle  = 1'b1;
        drain_idle = 1'b1;
    endtask

    // Result side: pop with random stalls
    always @(posedge clk) begin
        if (!rst_n) begin
            pop        <= 1'b0;
            drain_wait <= 0;
        end else if (drain_wait > 0) begin
            pop        <= 1'b0;
            drain_wait <= drain_wait - 1;
        end else begin
            pop <= 1'b1;
            if (drain_idle && $urandom_range(0, 3) == 0) begin
                drain_wait <= pick_gap();
            end
        end
    end

    // Compare every accepted result with the oldest one owed
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && pop && !empty) begin
            if (pending_events.size() == 0) begin
                flag_mismatch("result with none owed", 64'(out_item), '0);
            end else begin
                want = pending_events.pop_front();
                if (out_item.kind !== want.kind) begin
                    flag_mismatch("kind", 64'(out_item.kind), 64'(want.kind));
                end
                if (out_item.track_id !== want.track_id) begin
                    flag_mismatch("track_id", 64'(out_item.track_id), 64'(want.track_id));
                end
                if (out_item.velocity !== want.velocity) begin
                    flag_mismatch("velocity", 64'(out_item.velocity), 64'(want.velocity));
                end
                if (out_item.program_out !== want.program_out) begin
                    flag_mismatch("program_out", 64'(out_item.program_out),
                                  64'(want.program_out));
                end
                if (out_item.read_value !== want.read_value) begin
                    flag_mismatch("read_value", 64'(out_item.read_value),
                                  64'(want.read_value));
                end
                if (out_item.playing_out !== want.playing_out) begin
                    flag_mismatch("playing_out", 64'(out_item.playing_out),
                                  64'(want.playing_out));
                end
                if (out_item.last !== want.last) begin
                    flag_mismatch("last", 64'(out_item.last), 64'(want.last));
                end
            end
        end
    end

    initial begin
        foreach (pat_masks[s]) begin
            pat_masks[s] = '0;
        end
        run_on         = 1'b0;
        loop_on        = 1'b0;
        step_now       = '0;
        step_prev      = '0;
        prev_known     = 1'b0;
        ticks_per_step = 0;
        ticks_left     = 0;
        tempo_reg      = 8'd120;
        program_reg    = 8'd0;
        velocity_reg   = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_up();
        test_pattern_edits();
        test_single_pass();
        test_loop_restart();
        test_slow_tempo();
        test_random();

        wait_idle();
        if (pending_events.size() == 0 && fault_count == 0) begin
            $display("drum_step_sequencer: match");
        end else begin
            $display("drum_step_sequencer: mismatch");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #300_000_000;
        $display("drum_step_sequencer: mismatch");
        $finish;
    end

endmodule
